[sv/cfd_pkg.sv]
package cfd_pkg;

	localparam int unsigned FRAME_BYTES = 128;
	localparam int unsigned KEPT_DEPTH  = 10;
	localparam int unsigned KEPT_IDX_W  = $clog2(KEPT_DEPTH + 1);

	localparam logic [7:0]  OPEN_MARK  = 8'h24;
	localparam logic [7:0]  CLOSE_MARK = 8'h23;
	localparam logic [7:0]  COMMA      = 8'h2c;
	localparam logic [15:0] NO_ID      = 16'd999;

	localparam logic [7:0] CLASS_PAIR_ID = 8'd4;
	localparam logic [7:0] CLASS_BYTE_A  = 8'd7;
	localparam logic [7:0] CLASS_BYTE_B  = 8'd8;
	localparam logic [7:0] CLASS_FIRST_A = 8'd10;
	localparam logic [7:0] CLASS_FIRST_B = 8'd11;
	localparam logic [7:0] BOX_CLASS_LO  = 8'd1;
	localparam logic [7:0] BOX_CLASS_HI  = 8'd9;

	typedef logic [KEPT_DEPTH-1:0][7:0] kept_t;

	typedef struct packed {
		logic       good;
		logic [7:0] class_byte;
	} frame_view_t;

	typedef struct packed {
		logic [7:0]  class_code;
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
		logic [15:0] object_id;
	} result_t;

endpackage

[sv/cfd_frame.sv]
module cfd_frame #(
	parameter int unsigned FRAME_BYTES = cfd_pkg::FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output cfd_pkg::frame_view_t view,
	output cfd_pkg::kept_t      kept
);

	localparam logic [7:0] FRAME_LIMIT = 8'(FRAME_BYTES);
	localparam logic [cfd_pkg::KEPT_IDX_W-1:0] KEPT_FULL =
		cfd_pkg::KEPT_IDX_W'(cfd_pkg::KEPT_DEPTH);

	logic                           in_frame_q;
	logic                           length_known_q;
	logic [7:0]                     frame_length_q;
	logic [7:0]                     stored_count_q;
	logic [7:0]                     byte_sum_q;
	logic [7:0]                     last_byte_q;
	logic [7:0]                     class_byte_q;
	logic [7:0]                     payload_count_q;
	logic                           comma_skipped_q;
	logic [cfd_pkg::KEPT_IDX_W-1:0] kept_count_q;
	cfd_pkg::kept_t                 kept_q;

	logic       closing;
	logic       in_payload;
	logic [7:0] payload_pos;

	assign closing = (rx_byte == cfd_pkg::CLOSE_MARK) && length_known_q &&
		(stored_count_q == frame_length_q);
	assign payload_pos = stored_count_q - 8'd4;
	assign in_payload = (stored_count_q >= 8'd4) && (payload_pos < payload_count_q);

	assign view.good = step && in_frame_q && closing &&
		((byte_sum_q - last_byte_q) == last_byte_q);
	assign view.class_byte = class_byte_q;
	assign kept = kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			length_known_q  <= 1'b0;
			frame_length_q  <= '0;
			stored_count_q  <= '0;
			byte_sum_q      <= '0;
			last_byte_q     <= '0;
			class_byte_q    <= '0;
			payload_count_q <= '0;
			comma_skipped_q <= 1'b0;
			kept_count_q    <= '0;
			kept_q          <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_byte == cfd_pkg::OPEN_MARK) begin
					in_frame_q      <= 1'b1;
					length_known_q  <= 1'b0;
					frame_length_q  <= '0;
					stored_count_q  <= '0;
					byte_sum_q      <= '0;
					last_byte_q     <= '0;
					class_byte_q    <= '0;
					payload_count_q <= '0;
					comma_skipped_q <= 1'b0;
					kept_count_q    <= '0;
					kept_q          <= '0;
				end
			end else if (closing || stored_count_q >= FRAME_LIMIT) begin
				in_frame_q <= 1'b0;
			end else begin
				case (stored_count_q)
					8'd0: begin
						frame_length_q <= rx_byte;
						length_known_q <= 1'b1;
					end
					8'd1: class_byte_q <= rx_byte;
					8'd3: payload_count_q <= rx_byte;
					default: begin
						if (in_payload) begin
							if (rx_byte == cfd_pkg::COMMA && !comma_skipped_q) begin
								comma_skipped_q <= 1'b1;
							end else begin
								comma_skipped_q <= 1'b0;
								if (kept_count_q < KEPT_FULL) begin
									kept_q[kept_count_q] <= rx_byte;
									kept_count_q <= kept_count_q + 1'b1;
								end
							end
						end
					end
				endcase
				byte_sum_q     <= byte_sum_q + rx_byte;
				last_byte_q    <= rx_byte;
				stored_count_q <= stored_count_q + 8'd1;
			end
		end
	end

endmodule

[sv/cfd_extract.sv]
module cfd_extract (
	input  logic [7:0]       class_byte,
	input  cfd_pkg::kept_t   kept,
	output cfd_pkg::result_t res
);

	logic has_box;

	always_comb begin
		has_box = class_byte inside {[cfd_pkg::BOX_CLASS_LO:cfd_pkg::BOX_CLASS_HI]};
		res.class_code = class_byte;
		res.box_x = has_box ? {kept[1], kept[0]} : 16'd0;
		res.box_y = has_box ? {kept[3], kept[2]} : 16'd0;
		res.box_w = has_box ? {kept[5], kept[4]} : 16'd0;
		res.box_h = has_box ? {kept[7], kept[6]} : 16'd0;
		case (class_byte)
			cfd_pkg::CLASS_PAIR_ID: res.object_id = {kept[8], kept[9]};
			cfd_pkg::CLASS_BYTE_A,
			cfd_pkg::CLASS_BYTE_B:  res.object_id = {8'd0, kept[8]};
			cfd_pkg::CLASS_FIRST_A,
			cfd_pkg::CLASS_FIRST_B: res.object_id = {8'd0, kept[0]};
			default:                res.object_id = cfd_pkg::NO_ID;
		endcase
	end

endmodule

[sv/checked_frame_deframer_field_extract.sv]
// A closing '#' passes the byte register; its result is loaded into res_q.
// Throughput: one byte per cycle; the byte register advances whenever the
// result register is empty or being taken.
// Reset (arst_n, asynchronous, active low) clears all frame state and both
// valid flags; the block waits for '$'.
module checked_frame_deframer_field_extract #(
	parameter int unsigned FRAME_BYTES = cfd_pkg::FRAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  class_code,
	output logic [15:0] box_x,
	output logic [15:0] box_y,
	output logic [15:0] box_w,
	output logic [15:0] box_h,
	output logic [15:0] object_id
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 res_load;
	cfd_pkg::frame_view_t view;
	cfd_pkg::kept_t       kept;
	cfd_pkg::result_t     res_d;
	cfd_pkg::result_t     res_q;

	assign advance  = !res_valid || !res_stall;
	assign rx_stall = valid_s1 && !advance;
	assign res_load = view.good;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	cfd_frame #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.view    (view),
		.kept    (kept)
	);

	cfd_extract u_extract (
		.class_byte (view.class_byte),
		.kept       (kept),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign class_code = res_q.class_code;
	assign box_x      = res_q.box_x;
	assign box_y      = res_q.box_y;
	assign box_w      = res_q.box_w;
	assign box_h      = res_q.box_h;
	assign object_id  = res_q.object_id;

	// result register never overwritten while a stalled result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(res_valid && res_stall))
		else $error("result overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid)
		else $error("loaded result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && res_valid && res_stall))
		else $error("input stalled without back-pressure");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (class_code == 8'd0 || class_code > cfd_pkg::BOX_CLASS_HI)) |->
		(box_x == 16'd0 && box_y == 16'd0 && box_w == 16'd0 && box_h == 16'd0))
		else $error("box fields set for a class without box");

endmodule

[tb/tb_checked_frame_deframer_field_extract.sv]
`timescale 1ns / 100ps
module tb_checked_frame_deframer_field_extract;
	import cfd_pkg::*;

	typedef logic [7:0] octet_q_t[$];

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        rx_valid  = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte   = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  class_code;
	logic [15:0] box_x;
	logic [15:0] box_y;
	logic [15:0] box_w;
	logic [15:0] box_h;
	logic [15:0] object_id;

	logic [7:0] tx_bytes[$];
	result_t    expected_results[$];
	int         queued_total  = 0;
	int         send_idle_pct = 0;
	int         stall_pct     = 0;
	int         hold_asks     = 0;
	int         hold_taken    = 0;
	int         hold_left     = 0;
	int         fault_count   = 0;

	// mirror of the deframer state
	bit         in_frm;
	bit         len_seen;
	logic [7:0] frm_len;
	logic [7:0] stored_n;
	logic [7:0] run_sum;
	logic [7:0] tail_byte;
	logic [7:0] frm_class;
	logic [7:0] pay_count;
	bit         comma_dropped;
	int         kept_n;
	logic [7:0] kept[KEPT_DEPTH];

	checked_frame_deframer_field_extract uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.class_code (class_code),
		.box_x      (box_x),
		.box_y      (box_y),
		.box_w      (box_w),
		.box_h      (box_h),
		.object_id  (object_id)
	);

	always #5 clk = ~clk;

	function automatic void clear_frame_state();
		in_frm        = 1'b0;
		len_seen      = 1'b0;
		frm_len       = 8'h00;
		stored_n      = 8'h00;
		run_sum       = 8'h00;
		tail_byte     = 8'h00;
		frm_class     = 8'h00;
		pay_count     = 8'h00;
		comma_dropped = 1'b0;
		kept_n        = 0;
		foreach (kept[i])
			kept[i] = 8'h00;
	endfunction

	// Returns 1 when the byte closes a good frame; r then holds the fields.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		logic [7:0] lead_sum;
		bit         good;
		bit         has_box;
		r = '0;
		if (!in_frm) begin
			if (b == OPEN_MARK) begin
				clear_frame_state();
				in_frm = 1'b1;
			end
			return 1'b0;
		end
		if (b == CLOSE_MARK && len_seen && stored_n == frm_len) begin
			lead_sum = run_sum - tail_byte;
			good     = (lead_sum == tail_byte);
			has_box  = (frm_class >= BOX_CLASS_LO) && (frm_class <= BOX_CLASS_HI);
			r.class_code = frm_class;
			if (has_box) begin
				r.box_x = {kept[1], kept[0]};
				r.box_y = {kept[3], kept[2]};
				r.box_w = {kept[5], kept[4]};
				r.box_h = {kept[7], kept[6]};
			end
			if (frm_class == CLASS_PAIR_ID)
				r.object_id = {kept[8], kept[9]};
			else if (frm_class == CLASS_BYTE_A || frm_class == CLASS_BYTE_B)
				r.object_id = {8'h00, kept[8]};
			else if (frm_class == CLASS_FIRST_A || frm_class == CLASS_FIRST_B)
				r.object_id = {8'h00, kept[0]};
			else
				r.object_id = NO_ID;
			clear_frame_state();
			return good;
		end
		if (stored_n >= FRAME_BYTES) begin
			clear_frame_state();
			return 1'b0;
		end
		if (stored_n == 8'd0) begin
			frm_len  = b;
			len_seen = 1'b1;
		end else if (stored_n == 8'd1) begin
			frm_class = b;
		end else if (stored_n == 8'd3) begin
			pay_count = b;
		end else if (stored_n >= 8'd4 && (stored_n - 8'd4) < pay_count) begin
			if (b == COMMA && !comma_dropped) begin
				comma_dropped = 1'b1;
			end else begin
				comma_dropped = 1'b0;
				if (kept_n < KEPT_DEPTH) begin
					kept[kept_n] = b;
					kept_n++;
				end
			end
		end
		run_sum   = run_sum + b;
		tail_byte = b;
		stored_n  = stored_n + 8'd1;
		return 1'b0;
	endfunction

	task automatic check_field(input string tag, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, tag, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		result_t r;
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || !rx_stall) begin
			if (rx_valid) begin
				if (deframe_byte(rx_byte, r))
					expected_results.push_back(r);
			end
			if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rx_valid <= 1'b1;
				rx_byte  <= tx_bytes.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		result_t seen;
		result_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				seen = {class_code, box_x, box_y, box_w, box_h, object_id};
				if (expected_results.size() == 0) begin
					$display("%0t: result with no frame pending, class %h", $time,
						seen.class_code);
					fault_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("class_code", want.class_code, seen.class_code);
					check_field("box_x", want.box_x, seen.box_x);
					check_field("box_y", want.box_y, seen.box_y);
					check_field("box_w", want.box_w, seen.box_w);
					check_field("box_h", want.box_h, seen.box_h);
					check_field("object_id", want.object_id, seen.object_id);
				end
			end
			if (hold_asks != hold_taken) begin
				hold_taken <= hold_asks;
				hold_left  <= 80;
				res_stall  <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic void offer(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued_total++;
	endfunction

	function automatic logic [7:0] outside_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == OPEN_MARK) ? CLOSE_MARK : b;
	endfunction

	function automatic octet_q_t random_body(input int n);
		octet_q_t q;
		repeat (n)
			q.push_back(($urandom_range(3) == 0) ? COMMA : 8'($urandom_range(255)));
		return q;
	endfunction

	function automatic logic [7:0] pick_class();
		int r;
		r = $urandom_range(15);
		return (r <= 12) ? 8'(r) : 8'($urandom_range(255));
	endfunction

	function automatic void offer_frame(input logic [7:0] cls, input logic [7:0] cnt,
			input octet_q_t body, input bit spoil);
		logic [7:0] len;
		logic [7:0] b2;
		logic [7:0] sum;
		len = 8'(5 + body.size());
		b2  = 8'($urandom_range(255));
		sum = len + cls + b2 + cnt;
		foreach (body[i])
			sum += body[i];
		offer(OPEN_MARK);
		offer(len);
		offer(cls);
		offer(b2);
		offer(cnt);
		foreach (body[i])
			offer(body[i]);
		offer(spoil ? (sum ^ 8'($urandom_range(1, 255))) : sum);
		offer(CLOSE_MARK);
	endfunction

	task automatic gen_random(input int n_items);
		int         stop;
		int         kind;
		int         n;
		int         len;
		logic [7:0] cls;
		logic [7:0] cnt;
		logic [7:0] b;
		logic [7:0] sum;
		stop = queued_total + n_items;
		while (queued_total < stop) begin
			kind = $urandom_range(99);
			cls  = pick_class();
			if (kind < 8) begin
				repeat ($urandom_range(1, 4))
					offer(outside_byte());
			end else if (kind < 11) begin
				// header cut short
				len = $urandom_range(1, 4);
				offer(OPEN_MARK);
				offer(8'(len));
				sum = 8'(len);
				for (int i = 1; i < len - 1; i++) begin
					b = 8'($urandom_range(255));
					offer(b);
					sum += b;
				end
				if (len > 1)
					offer($urandom_range(1) ? sum : 8'($urandom_range(255)));
				offer(CLOSE_MARK);
			end else if (kind < 13) begin
				// frame broken off; the next '$' is taken as frame data
				offer(OPEN_MARK);
				repeat ($urandom_range(1, 6))
					offer(outside_byte());
			end else if (kind < 16) begin
				if ($urandom_range(1)) begin
					offer_frame(cls, 8'($urandom_range(255)), random_body(FRAME_BYTES - 5),
						1'b0);
				end else begin
					offer(OPEN_MARK);
					offer($urandom_range(1) ? 8'h00 : 8'($urandom_range(FRAME_BYTES + 1, 255)));
					repeat (FRAME_BYTES + 1)
						offer(outside_byte());
				end
			end else begin
				n   = ($urandom_range(4) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 14);
				cnt = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'(n);
				offer_frame(cls, cnt, random_body(n), kind < 26);
			end
		end
	endtask

	task automatic drain_input();
		while (tx_bytes.size() != 0 || rx_valid)
			@(negedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stalls, input int n_items);
		send_idle_pct = idle_pct;
		stall_pct     = stalls;
		gen_random(n_items);
		drain_input();
	endtask

	initial begin : sequencer
		octet_q_t body;
		int       guard;
		clear_frame_state();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		offer(CLOSE_MARK);
		offer(8'hff);
		offer(8'h00);
		offer(OPEN_MARK);
		offer(8'd2);
		offer(8'd2);
		offer(CLOSE_MARK);
		body = '{8'hff, 8'hff, COMMA, COMMA, COMMA, 8'h00, OPEN_MARK, CLOSE_MARK,
			8'h80, 8'h01, 8'h7f};
		offer_frame(CLASS_PAIR_ID, 8'd11, body, 1'b0);
		drain_input();

		hold_asks++;
		run_phase(0, 0, 300);
		run_phase(69, 0, 300);
		run_phase(0, 69, 300);
		run_phase(15, 15, 300);

		stall_pct = 0;
		guard = 0;
		while (expected_results.size() != 0 && guard < 2000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
